FILE: hdl/tdq_pkg.sv
// Shared types and constants for the tick-timed delay queue.
package tdq_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_DELAY  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  localparam int TASK_W      = 8;
  localparam int DELAY_W     = 31;
  localparam int TIME_W      = 32;
  localparam int ACC_W       = 64;
  localparam int INC_W       = 40;
  localparam logic [INC_W-1:0] INC_RESET = 40'd235899210422;

  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  localparam int UB_WOKEN    = 0;
  localparam int UB_STATUS   = 1;

endpackage

FILE: hdl/tick_timed_delay_queue.sv
// Top level: fixed-point ms clock and wake-time sorted task queue with a sequencer.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser opcode, tdata task_id + delay_ms
//  out_    | out | out_tvalid/out_tready| tuser woken/status, tdata task + now, tlast
//  cfg_    | in  | cfg_we               | cfg_wdata ms increment (8.32)
//
// One item at a time; in_tready is high only while the sequencer is idle.
// Tick: S_TRD, then S_TCHK once per woken task and once more if it stops at an entry not yet due;
// cancel: S_CSTART, then S_CCHK per entry. Delay: S_IRD and S_ICHK per entry moved; S_DONE if full.
// Every queue entry goes through the single queue RAM port pair, one per cycle while not stalled.
// A result waits in the output register; the sequencer stalls only when a new one is due.
// rst_n is synchronous; queue entries are not cleared, the fill count makes them invalid.
module tick_timed_delay_queue #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tdq_pkg::IN_TDATA_W-1:0]  in_tdata,   // task_id, delay_ms, zero pad
  input  logic [tdq_pkg::IN_TUSER_W-1:0]  in_tuser,   // opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tdq_pkg::OUT_TDATA_W-1:0] out_tdata,  // woken_task, now_ms
  output logic [tdq_pkg::OUT_TUSER_W-1:0] out_tuser,  // woken_valid, status
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [tdq_pkg::INC_W-1:0]       cfg_wdata
);
  import tdq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TB = TASK_ID_BITS;
  localparam int EW = TIME_W + TB;

  typedef enum logic [2:0] {
    S_IDLE, S_TRD, S_TCHK, S_IRD, S_ICHK, S_CSTART, S_CCHK, S_DONE
  } state_t;

  state_t              state_r;
  logic [ACC_W-1:0]    acc_r;
  logic [INC_W-1:0]    inc_r;
  logic [CW-1:0]       count_r;
  logic [AW-1:0]       head_r;
  logic [CW-1:0]       idx_r;
  logic [CW-1:0]       wr_r;
  logic [RES_CNT_W-1:0] n_r;
  logic [TB-1:0]       tid_r;
  logic [TIME_W-1:0]   wake_r;
  logic                st_r;
  logic                pend_v_r;
  logic [TB-1:0]       pend_r;

  logic                out_valid_r;
  logic                out_woken_r;
  logic                out_status_r;
  logic                out_last_r;
  logic [TASK_W-1:0]   out_task_r;
  logic [TIME_W-1:0]   out_now_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_rdata;

  logic                accept;
  logic                out_free;
  logic                out_load;
  logic [TIME_W-1:0]   now;
  logic [TIME_W-1:0]   rd_wake;
  logic [TB-1:0]       rd_task;
  logic [TB+TASK_W-1:0] in_tid_wide;
  logic [TB+TASK_W-1:0] pend_wide;
  logic [ACC_W-1:0]    acc_sum;
  logic                due;
  logic                later;
  logic                keep;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(off);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign accept      = in_tvalid && in_tready;
  assign in_tready   = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_tready;
  assign out_load    = ((state_r == S_DONE) && out_free) ||
                       ((state_r == S_TCHK) && due && pend_v_r && out_free);
  assign now         = acc_r[ACC_W-1 -: TIME_W];
  assign acc_sum     = acc_r + ACC_W'(inc_r);
  assign rd_wake     = ram_rdata[EW-1 -: TIME_W];
  assign rd_task     = ram_rdata[TB-1:0];
  assign in_tid_wide = {{TB{1'b0}}, in_tdata[TASK_W-1:0]};
  assign pend_wide   = {{TASK_W{1'b0}}, pend_r};
  assign due         = !($signed(rd_wake) > $signed(now));
  assign later       = $signed(rd_wake) > $signed(wake_r);
  assign keep        = (rd_task != tid_r);

  assign out_tvalid  = out_valid_r;
  assign out_tdata   = {out_now_r, out_task_r};
  assign out_tuser   = {out_status_r, out_woken_r};
  assign out_tlast   = out_last_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_r;
    ram_wdata = {wake_r, tid_r};
    ram_raddr = head_r;
    case (state_r)
      S_TCHK: begin
        if (due && (!pend_v_r || out_free)) begin
          ram_raddr = phys(head_r, CW'(1));
        end
      end
      S_IRD: begin
        if (idx_r == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = phys(head_r, idx_r - CW'(1));
        end
      end
      S_ICHK: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, idx_r);
        if (later) begin
          ram_wdata = ram_rdata;
          if (idx_r > CW'(1)) begin
            ram_raddr = phys(head_r, idx_r - CW'(2));
          end
        end
      end
      S_CCHK: begin
        ram_we    = keep;
        ram_waddr = phys(head_r, wr_r);
        ram_wdata = ram_rdata;
        ram_raddr = phys(head_r, idx_r + CW'(1));
      end
      default: begin
      end
    endcase
  end

  tdq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      inc_r       <= INC_RESET;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      st_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        inc_r <= cfg_wdata;
      end
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            tid_r    <= in_tid_wide[TB-1:0];
            wake_r   <= now + TIME_W'(in_tdata[TASK_W +: DELAY_W]);
            pend_v_r <= 1'b0;
            st_r     <= (opcode_t'(in_tuser) == OP_DELAY) && (count_r == CW'(QUEUE_DEPTH));
            n_r      <= '0;
            idx_r    <= count_r;
            case (opcode_t'(in_tuser))
              OP_TICK: begin
                acc_r   <= acc_sum;
                state_r <= S_TRD;
              end
              OP_DELAY: begin
                if (count_r == CW'(QUEUE_DEPTH)) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_IRD;
                end
              end
              OP_CANCEL: state_r <= S_CSTART;
              default:   state_r <= S_DONE;
            endcase
          end
        end
        S_TRD: begin
          state_r <= (count_r == '0) ? S_DONE : S_TCHK;
        end
        S_TCHK: begin
          if (!due) begin
            state_r <= S_DONE;
          end else if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_valid_r  <= 1'b1;
              out_woken_r  <= 1'b1;
              out_task_r   <= pend_wide[TASK_W-1:0];
              out_status_r <= 1'b0;
              out_last_r   <= 1'b0;
              out_now_r    <= now;
            end
            pend_r   <= rd_task;
            pend_v_r <= 1'b1;
            head_r   <= phys(head_r, CW'(1));
            count_r  <= count_r - CW'(1);
            n_r      <= n_r + RES_CNT_W'(1);
            if (count_r == CW'(1) || n_r == RES_CNT_W'(MAX_RESULTS - 1)) begin
              state_r <= S_DONE;
            end
          end
        end
        S_IRD: begin
          if (idx_r == '0) begin
            count_r <= count_r + CW'(1);
            state_r <= S_DONE;
          end else begin
            state_r <= S_ICHK;
          end
        end
        S_ICHK: begin
          if (later) begin
            idx_r <= idx_r - CW'(1);
            if (idx_r == CW'(1)) begin
              state_r <= S_IRD;
            end
          end else begin
            count_r <= count_r + CW'(1);
            state_r <= S_DONE;
          end
        end
        S_CSTART: begin
          idx_r   <= '0;
          wr_r    <= '0;
          state_r <= (count_r == '0) ? S_DONE : S_CCHK;
        end
        S_CCHK: begin
          idx_r <= idx_r + CW'(1);
          if (keep) begin
            wr_r <= wr_r + CW'(1);
          end
          if (idx_r + CW'(1) == count_r) begin
            count_r <= keep ? wr_r + CW'(1) : wr_r;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_woken_r  <= pend_v_r;
            out_task_r   <= pend_v_r ? pend_wide[TASK_W-1:0] : '0;
            out_status_r <= st_r;
            out_last_r   <= 1'b1;
            out_now_r    <= now;
            pend_v_r     <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_tick_adds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == OP_TICK) |=> acc_r == $past(acc_sum))
    else $error("tick did not advance the clock by the increment");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input ready right after a transfer");

  a_woken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[UB_WOKEN]) |-> !out_tuser[UB_STATUS])
    else $error("woken result carries full status");
`endif

endmodule

FILE: hdl/tdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tdq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: test/tick_timed_delay_queue_tb.sv
// Testbench for the tick-timed delay queue: directed and random transfers checked against a queue model.

class delay_queue_scoreboard;
  localparam int DEPTH = 16;

  typedef struct packed {
    logic        woken_valid;
    logic [7:0]  woken_task;
    logic [31:0] now_ms;
    logic        status;
    logic        last;
  } wake_result_t;

  logic [tdq_pkg::INC_W-1:0] ms_step;
  logic [tdq_pkg::ACC_W-1:0] clock_acc;
  logic [31:0]               wake_at [DEPTH];
  logic [7:0]                sleeper [DEPTH];
  int                        fill;
  wake_result_t              pending_results[$];
  int                        mismatches;

  function new();
    ms_step    = tdq_pkg::INC_RESET;
    clock_acc  = '0;
    fill       = 0;
    mismatches = 0;
  endfunction

  function void set_step(logic [tdq_pkg::INC_W-1:0] value);
    ms_step = value;
  endfunction

  function logic [31:0] current_ms();
    return clock_acc[63:32];
  endfunction

  function void push_result(logic valid, logic [7:0] tid, logic status, logic last);
    wake_result_t r;
    r.woken_valid = valid;
    r.woken_task  = tid;
    r.now_ms      = current_ms();
    r.status      = status;
    r.last        = last;
    pending_results.push_back(r);
  endfunction

  function void drop_entry(int pos);
    for (int i = pos; i + 1 < fill; i++) begin
      wake_at[i] = wake_at[i + 1];
      sleeper[i] = sleeper[i + 1];
    end
    fill--;
  endfunction

  function void note_input(tdq_pkg::opcode_t op, logic [7:0] tid, logic [30:0] dly);
    logic [31:0] wake;
    int          pos;
    int          n;
    case (op)
      tdq_pkg::OP_TICK: begin
        clock_acc = clock_acc + {24'd0, ms_step};
        n = 0;
        while (fill > 0 && n < tdq_pkg::MAX_RESULTS &&
               $signed(wake_at[0]) <= $signed(current_ms())) begin
          push_result(1'b1, sleeper[0], 1'b0, 1'b0);
          drop_entry(0);
          n++;
        end
        if (n == 0) push_result(1'b0, 8'd0, 1'b0, 1'b1);
        else pending_results[pending_results.size() - 1].last = 1'b1;
      end
      tdq_pkg::OP_DELAY: begin
        if (fill >= DEPTH) begin
          push_result(1'b0, 8'd0, 1'b1, 1'b1);
        end else begin
          wake = current_ms() + {1'b0, dly};
          pos  = 0;
          while (pos < fill && $signed(wake_at[pos]) <= $signed(wake)) pos++;
          for (int i = fill; i > pos; i--) begin
            wake_at[i] = wake_at[i - 1];
            sleeper[i] = sleeper[i - 1];
          end
          wake_at[pos] = wake;
          sleeper[pos] = tid;
          fill++;
          push_result(1'b0, 8'd0, 1'b0, 1'b1);
        end
      end
      tdq_pkg::OP_CANCEL: begin
        pos = 0;
        while (pos < fill) begin
          if (sleeper[pos] == tid) drop_entry(pos);
          else pos++;
        end
        push_result(1'b0, 8'd0, 1'b0, 1'b1);
      end
      default: push_result(1'b0, 8'd0, 1'b0, 1'b1);
    endcase
  endfunction

  function void check_result(logic valid, logic [7:0] tid, logic [31:0] now,
                             logic status, logic last);
    wake_result_t exp_r;
    if (pending_results.size() == 0) begin
      $error("result transfer with nothing expected: task %0h now %0h", tid, now);
      mismatches++;
      return;
    end
    exp_r = pending_results.pop_front();
    if (valid !== exp_r.woken_valid) begin
      $error("woken_valid: expected %0d, actual %0d", exp_r.woken_valid, valid);
      mismatches++;
    end
    if (tid !== exp_r.woken_task) begin
      $error("woken_task: expected %0h, actual %0h", exp_r.woken_task, tid);
      mismatches++;
    end
    if (now !== exp_r.now_ms) begin
      $error("now_ms: expected %0h, actual %0h", exp_r.now_ms, now);
      mismatches++;
    end
    if (status !== exp_r.status) begin
      $error("status: expected %0d, actual %0d", exp_r.status, status);
      mismatches++;
    end
    if (last !== exp_r.last) begin
      $error("last: expected %0d, actual %0d", exp_r.last, last);
      mismatches++;
    end
  endfunction
endclass

module tick_timed_delay_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tdq_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 36;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // task_id, delay_ms, zero pad
  logic [IN_TUSER_W-1:0]  in_tuser;   // opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // woken_task, now_ms
  logic [OUT_TUSER_W-1:0] out_tuser;  // woken_valid, status
  logic                   out_tlast;
  logic                   cfg_we;
  logic [INC_W-1:0]       cfg_wdata;

  delay_queue_scoreboard model = new();
  int                    idle_cycles = 0;
  int                    burst_left  = 0;
  int                    rx_seg_left = 0;
  int                    rx_mode     = 0;

  tick_timed_delay_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // receiver: segments of always-ready, coin-flip and mostly-stalled
  always @(negedge clk) begin
    if (rx_seg_left == 0) begin
      rx_mode     = $urandom_range(0, 2);
      rx_seg_left = $urandom_range(5, 40);
    end else begin
      rx_seg_left--;
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      model.check_result(out_tuser[UB_WOKEN], out_tdata[7:0], out_tdata[39:8],
                         out_tuser[UB_STATUS], out_tlast);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tick_timed_delay_queue verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input opcode_t op, input logic [7:0] tid, input logic [30:0] dly);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, dly, tid};
    do @(posedge clk); while (!in_tready);
    model.note_input(op, tid, dly);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (model.pending_results.size() != 0) @(posedge clk);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_step(input logic [INC_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    model.set_step(value);
  endtask

  task automatic random_item(output opcode_t op, output logic [7:0] tid,
                             output logic [30:0] dly);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 36)      op = OP_TICK;
    else if (pick < 76) op = OP_DELAY;
    else if (pick < 88) op = OP_CANCEL;
    else                op = OP_READ;
    tid = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    dly = ($urandom_range(0, 6) == 0) ? 31'($urandom) : 31'($urandom_range(0, 400));
  endtask

  initial begin
    logic [INC_W-1:0] steps [7];
    opcode_t          op;
    logic [7:0]       tid;
    logic [30:0]      dly;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(OP_READ, 8'd0, 31'd0);
    send_item(OP_TICK, 8'hFF, 31'h7FFF_FFFF);
    send_item(OP_DELAY, 8'd0, 31'd0);
    send_item(OP_DELAY, 8'hFF, 31'h7FFF_FFFF);  // wake time wraps negative
    send_item(OP_DELAY, 8'h5A, 31'h2AAA_AAAA);
    send_item(OP_CANCEL, 8'h5A, 31'h5555_5555);
    send_item(OP_CANCEL, 8'h77, 31'd0);          // absent task
    send_item(OP_TICK, 8'd0, 31'd0);
    for (int i = 0; i < 16; i++) send_item(OP_DELAY, 8'(i % 4 + 1), 31'(i / 3));
    send_item(OP_DELAY, 8'hAA, 31'd0);           // queue full
    send_item(OP_TICK, 8'd0, 31'd0);             // every entry due

    steps[0] = '0;
    steps[1] = '1;
    steps[2] = 40'd1;
    steps[3] = 40'h01_0000_0000;
    steps[4] = INC_W'({$urandom, $urandom});
    steps[5] = INC_RESET;
    steps[6] = INC_W'({$urandom, $urandom});
    foreach (steps[p]) begin
      write_step(steps[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        random_item(op, tid, dly);
        send_item(op, tid, dly);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (model.mismatches == 0)
      $display("tick_timed_delay_queue verification clean");
    else
      $display("tick_timed_delay_queue verification failed");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/tdq_pkg.sv
hdl/tdq_ram.sv
hdl/tick_timed_delay_queue.sv
test/tick_timed_delay_queue_tb.sv
